// File: sv/clt_pkg.sv
// Shared types, character codes and helpers for the chat line tokenizer.
// Used by clt_step and chat_line_tokenizer_unit; depends on nothing else.
package clt_pkg;

   // Character codes the grammar looks for
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // Number of digits in a numeric command
   localparam logic [1:0] CMD_DIGITS = 2'd3;

   // Grammar position within one line
   typedef enum logic [3:0] {
      PH_START       = 4'd0,
      PH_TAG_FIRST   = 4'd1,
      PH_TAG_BODY    = 4'd2,
      PH_TAG_SPACE   = 4'd3,
      PH_PFX_FIRST   = 4'd4,
      PH_PFX_BODY    = 4'd5,
      PH_PFX_SPACE   = 4'd6,
      PH_CMD_ALPHA   = 4'd7,
      PH_CMD_DIGIT   = 4'd8,
      PH_CMD_SPACE   = 4'd9,
      PH_MIDDLE      = 4'd10,
      PH_PAR_SPACE   = 4'd11,
      PH_TRAIL_FIRST = 4'd12,
      PH_TRAIL_BODY  = 4'd13,
      PH_CR_SEEN     = 4'd14,
      PH_ERROR       = 4'd15
   } phase_type;

   // Field kind tagged on each byte
   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_TAGS   = 3'd1,
      KIND_PREFIX = 3'd2,
      KIND_CMD    = 3'd3,
      KIND_PARAM  = 3'd4
   } kind_type;

   // Line status reported on LF
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_SYNTAX     = 2'd1,
      ST_TRAIL_SP   = 2'd2,
      ST_EMPTY_TRL  = 2'd3
   } status_type;

   // Parser state carried from byte to byte
   typedef struct packed {
      phase_type  phase;
      logic [3:0] param_count;
      logic [1:0] digit_count;
      status_type error_code;
      logic       field_open;
   } state_type;

   // One tagged output byte
   typedef struct packed {
      logic [7:0] data_byte;
      kind_type   field_kind;
      logic [3:0] param_number;
      logic       field_first;
      logic       line_end;
      status_type line_status;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_START,
      param_count: 4'd0,
      digit_count: 2'd0,
      error_code:  ST_OK,
      field_open:  1'b0
   };

   function automatic logic is_letter(input logic [7:0] b);
      return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction

endpackage

// File: sv/clt_step.sv
// Combinational parser step: one byte against the current grammar state.
// Produces the tagged result and the following state; uses clt_pkg.
module clt_step #(
   parameter int MAX_PARAMS = 16
) (
   input  clt_pkg::state_type  state_cur,
   input  logic [7:0]          byte_cur,
   output clt_pkg::state_type  state_in,
   output clt_pkg::result_type result_in
);

   localparam int          CapInt   = (MAX_PARAMS - 1 < 15) ? MAX_PARAMS - 1 : 15;
   localparam logic [3:0]  ParamCap = 4'(CapInt);

   clt_pkg::kind_type kind;
   logic              is_lf;
   logic              is_sp;
   logic              is_cr;
   logic              is_colon;
   logic              is_cmd_start;

   assign is_lf        = (byte_cur == clt_pkg::CH_LF);
   assign is_sp        = (byte_cur == clt_pkg::CH_SPACE);
   assign is_cr        = (byte_cur == clt_pkg::CH_CR);
   assign is_colon     = (byte_cur == clt_pkg::CH_COLON);
   assign is_cmd_start = clt_pkg::is_letter(byte_cur) || clt_pkg::is_digit(byte_cur);

   // Field kind of this byte, from the state it arrives in
   always_comb begin
      kind = clt_pkg::KIND_NONE;
      if (!is_lf) begin
         case (state_cur.phase)
            clt_pkg::PH_START: begin
               if (!(byte_cur == clt_pkg::CH_AT) && !is_colon && is_cmd_start)
                  kind = clt_pkg::KIND_CMD;
            end
            clt_pkg::PH_TAG_FIRST, clt_pkg::PH_TAG_BODY: begin
               if (!is_sp && !is_cr) kind = clt_pkg::KIND_TAGS;
            end
            clt_pkg::PH_TAG_SPACE: begin
               if (!is_sp && !is_colon && is_cmd_start) kind = clt_pkg::KIND_CMD;
            end
            clt_pkg::PH_PFX_FIRST, clt_pkg::PH_PFX_BODY: begin
               if (!is_sp && !is_cr) kind = clt_pkg::KIND_PREFIX;
            end
            clt_pkg::PH_PFX_SPACE: begin
               if (!is_sp && is_cmd_start) kind = clt_pkg::KIND_CMD;
            end
            clt_pkg::PH_CMD_ALPHA: begin
               if (clt_pkg::is_letter(byte_cur)) kind = clt_pkg::KIND_CMD;
            end
            clt_pkg::PH_CMD_DIGIT: begin
               if (clt_pkg::is_digit(byte_cur) &&
                   state_cur.digit_count < clt_pkg::CMD_DIGITS)
                  kind = clt_pkg::KIND_CMD;
            end
            clt_pkg::PH_CMD_SPACE: begin
               if (!is_colon && !is_sp && !is_cr) kind = clt_pkg::KIND_PARAM;
            end
            clt_pkg::PH_MIDDLE: begin
               if (!is_sp && !is_cr) kind = clt_pkg::KIND_PARAM;
            end
            clt_pkg::PH_PAR_SPACE: begin
               if (!is_sp && !is_cr && !is_colon) kind = clt_pkg::KIND_PARAM;
            end
            clt_pkg::PH_TRAIL_FIRST, clt_pkg::PH_TRAIL_BODY: begin
               if (!is_cr) kind = clt_pkg::KIND_PARAM;
            end
            default: kind = clt_pkg::KIND_NONE;
         endcase
      end
   end

   // Output tagging of the byte
   always_comb begin
      result_in.data_byte    = byte_cur;
      result_in.field_kind   = kind;
      result_in.param_number = (kind == clt_pkg::KIND_PARAM) ? state_cur.param_count : 4'd0;
      result_in.field_first  = (kind != clt_pkg::KIND_NONE) && !state_cur.field_open;
      result_in.line_end     = is_lf;
      result_in.line_status  = clt_pkg::ST_OK;
      if (is_lf)
         result_in.line_status = (state_cur.phase == clt_pkg::PH_CR_SEEN) ?
                                 state_cur.error_code : clt_pkg::ST_SYNTAX;
   end

   // Next grammar state
   always_comb begin
      state_in            = state_cur;
      state_in.field_open = (kind != clt_pkg::KIND_NONE);
      if (is_lf) begin
         state_in = clt_pkg::STATE_RESET;
      end else begin
         case (state_cur.phase)
            clt_pkg::PH_START: begin
               if (byte_cur == clt_pkg::CH_AT) state_in.phase = clt_pkg::PH_TAG_FIRST;
               else if (is_colon) state_in.phase = clt_pkg::PH_PFX_FIRST;
               else if (clt_pkg::is_letter(byte_cur)) state_in.phase = clt_pkg::PH_CMD_ALPHA;
               else if (clt_pkg::is_digit(byte_cur)) begin
                  state_in.phase       = clt_pkg::PH_CMD_DIGIT;
                  state_in.digit_count = 2'd1;
               end else begin
                  state_in.phase      = clt_pkg::PH_ERROR;
                  state_in.error_code = clt_pkg::ST_SYNTAX;
               end
            end
            clt_pkg::PH_TAG_FIRST, clt_pkg::PH_TAG_BODY: begin
               if (is_sp && state_cur.phase == clt_pkg::PH_TAG_BODY)
                  state_in.phase = clt_pkg::PH_TAG_SPACE;
               else if (is_sp || is_cr) begin
                  state_in.phase      = clt_pkg::PH_ERROR;
                  state_in.error_code = clt_pkg::ST_SYNTAX;
               end else state_in.phase = clt_pkg::PH_TAG_BODY;
            end
            clt_pkg::PH_TAG_SPACE: begin
               if (is_sp) state_in.phase = clt_pkg::PH_TAG_SPACE;
               else if (is_colon) state_in.phase = clt_pkg::PH_PFX_FIRST;
               else if (clt_pkg::is_letter(byte_cur)) state_in.phase = clt_pkg::PH_CMD_ALPHA;
               else if (clt_pkg::is_digit(byte_cur)) begin
                  state_in.phase       = clt_pkg::PH_CMD_DIGIT;
                  state_in.digit_count = 2'd1;
               end else begin
                  state_in.phase      = clt_pkg::PH_ERROR;
                  state_in.error_code = clt_pkg::ST_SYNTAX;
               end
            end
            clt_pkg::PH_PFX_FIRST, clt_pkg::PH_PFX_BODY: begin
               if (is_sp && state_cur.phase == clt_pkg::PH_PFX_BODY)
                  state_in.phase = clt_pkg::PH_PFX_SPACE;
               else if (is_sp || is_cr) begin
                  state_in.phase      = clt_pkg::PH_ERROR;
                  state_in.error_code = clt_pkg::ST_SYNTAX;
               end else state_in.phase = clt_pkg::PH_PFX_BODY;
            end
            clt_pkg::PH_PFX_SPACE: begin
               if (is_sp) state_in.phase = clt_pkg::PH_PFX_SPACE;
               else if (clt_pkg::is_letter(byte_cur)) state_in.phase = clt_pkg::PH_CMD_ALPHA;
               else if (clt_pkg::is_digit(byte_cur)) begin
                  state_in.phase       = clt_pkg::PH_CMD_DIGIT;
                  state_in.digit_count = 2'd1;
               end else begin
                  state_in.phase      = clt_pkg::PH_ERROR;
                  state_in.error_code = clt_pkg::ST_SYNTAX;
               end
            end
            clt_pkg::PH_CMD_ALPHA: begin
               if (clt_pkg::is_letter(byte_cur)) state_in.phase = clt_pkg::PH_CMD_ALPHA;
               else if (is_sp) state_in.phase = clt_pkg::PH_CMD_SPACE;
               else begin
                  state_in.phase      = clt_pkg::PH_ERROR;
                  state_in.error_code = clt_pkg::ST_SYNTAX;
               end
            end
            clt_pkg::PH_CMD_DIGIT: begin
               if (clt_pkg::is_digit(byte_cur) &&
                   state_cur.digit_count < clt_pkg::CMD_DIGITS)
                  state_in.digit_count = state_cur.digit_count + 2'd1;
               else if (is_sp && state_cur.digit_count == clt_pkg::CMD_DIGITS)
                  state_in.phase = clt_pkg::PH_CMD_SPACE;
               else begin
                  state_in.phase      = clt_pkg::PH_ERROR;
                  state_in.error_code = clt_pkg::ST_SYNTAX;
               end
            end
            clt_pkg::PH_CMD_SPACE: begin
               if (is_colon) state_in.phase = clt_pkg::PH_TRAIL_FIRST;
               else if (is_sp || is_cr) begin
                  state_in.phase      = clt_pkg::PH_ERROR;
                  state_in.error_code = clt_pkg::ST_SYNTAX;
               end else state_in.phase = clt_pkg::PH_MIDDLE;
            end
            clt_pkg::PH_MIDDLE: begin
               if (is_sp) begin
                  if (state_cur.param_count < ParamCap)
                     state_in.param_count = state_cur.param_count + 4'd1;
                  state_in.phase = clt_pkg::PH_PAR_SPACE;
               end else if (is_cr) begin
                  state_in.error_code = clt_pkg::ST_OK;
                  state_in.phase      = clt_pkg::PH_CR_SEEN;
               end
            end
            clt_pkg::PH_PAR_SPACE: begin
               if (is_sp) state_in.phase = clt_pkg::PH_PAR_SPACE;
               else if (is_cr) begin
                  state_in.error_code = clt_pkg::ST_TRAIL_SP;
                  state_in.phase      = clt_pkg::PH_CR_SEEN;
               end else if (is_colon) state_in.phase = clt_pkg::PH_TRAIL_FIRST;
               else state_in.phase = clt_pkg::PH_MIDDLE;
            end
            clt_pkg::PH_TRAIL_FIRST, clt_pkg::PH_TRAIL_BODY: begin
               if (is_cr) begin
                  state_in.error_code = (state_cur.phase == clt_pkg::PH_TRAIL_FIRST) ?
                                        clt_pkg::ST_EMPTY_TRL : clt_pkg::ST_OK;
                  state_in.phase      = clt_pkg::PH_CR_SEEN;
               end else state_in.phase = clt_pkg::PH_TRAIL_BODY;
            end
            clt_pkg::PH_CR_SEEN: begin
               state_in.phase      = clt_pkg::PH_ERROR;
               state_in.error_code = clt_pkg::ST_SYNTAX;
            end
            default: state_in.phase = state_cur.phase;
         endcase
      end
   end

endmodule

// File: sv/chat_line_tokenizer_unit.sv
// Chat line tokenizer: byte-serial grammar checker and field tagger.
// Bytes wait in the input register while the result register is stalled.
// Throughput: one byte per cycle when unstalled; the parser step between the
// input and result registers is the only per-byte work, and the state register
// closes that loop. Reset (synchronous, active high) empties both registers and
// returns the parser to start of line. Depends on clt_pkg and clt_step.
module chat_line_tokenizer_unit #(
   parameter int MAX_PARAMS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic [2:0] rsp_field_kind,
   output logic [3:0] rsp_param_number,
   output logic       rsp_field_first,
   output logic       rsp_line_end,
   output logic [1:0] rsp_line_status
);

   localparam int         CapInt   = (MAX_PARAMS - 1 < 15) ? MAX_PARAMS - 1 : 15;
   localparam logic [3:0] ParamCap = 4'(CapInt);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff,  in_byte_in;
   clt_pkg::state_type  state_ff,    state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   clt_pkg::result_type rsp_ff,      rsp_in;
   clt_pkg::state_type  step_state;
   clt_pkg::result_type step_result;
   logic                out_free;
   logic                advance;
   logic                req_take;

   // Handshake: the result register frees when empty or being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   clt_step #(
      .MAX_PARAMS (MAX_PARAMS)
   ) u_step (
      .state_cur (state_ff),
      .byte_cur  (in_byte_ff),
      .state_in  (step_state),
      .result_in (step_result)
   );

   // Next values: load on transaction, advance parser on move, else hold
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in   = req_take ? req_in_byte : in_byte_ff;
      state_in     = advance ? step_state : state_ff;
      rsp_valid_in = out_free ? advance : rsp_valid_ff;
      rsp_in       = advance ? step_result : rsp_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= clt_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_byte    = rsp_ff.data_byte;
   assign rsp_field_kind   = rsp_ff.field_kind;
   assign rsp_param_number = rsp_ff.param_number;
   assign rsp_field_first  = rsp_ff.field_first;
   assign rsp_line_end     = rsp_ff.line_end;
   assign rsp_line_status  = rsp_ff.line_status;

   // A processed LF leaves the parser at start of line
   a_lf_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && in_byte_ff == clt_pkg::CH_LF) |=>
         (state_ff.phase == clt_pkg::PH_START && state_ff.param_count == 4'd0))
      else $error("parser not restarted after LF");

   // Parameter index never passes its cap
   a_param_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff.param_count <= ParamCap)
      else $error("parameter index over cap");

   // First-of-field only on a tagged byte
   a_first_tagged: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.field_first) |-> rsp_ff.field_kind != clt_pkg::KIND_NONE)
      else $error("field start on untagged byte");

   // Parameter number zero outside parameters
   a_pnum_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.field_kind != clt_pkg::KIND_PARAM) |->
         rsp_ff.param_number == 4'd0)
      else $error("parameter number outside parameter");

   // Status only reported at line end
   a_status_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.line_end) |-> rsp_ff.line_status == clt_pkg::ST_OK)
      else $error("status away from line end");

endmodule
